// ===== src/psq_pkg.sv =====
// shared constants for the streaming quantile estimator
`default_nettype none
package psq_pkg;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COUNT_BITS_DEF  = 24;
    localparam int HEIGHT_BITS     = 32;
    localparam int FRAC_BITS       = 16;
    localparam int MARKERS         = 5;
    localparam int LEVEL_BITS      = 16;
    localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = 16'h8000;
    localparam logic REG_QLEVEL = 1'b0;
endpackage
`default_nettype wire

// ===== src/psq_div.sv =====
// restoring unsigned divider, one quotient bit per cycle
`default_nettype none
module psq_div #(
    parameter int NUM_BITS = 57,
    parameter int DEN_BITS = 24
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [NUM_BITS-1:0] num,
    input  wire logic [DEN_BITS-1:0] den,
    output logic                     done,
    output logic [NUM_BITS-1:0]      quot
);
    localparam int CNT_BITS = $clog2(NUM_BITS);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DEN_BITS-1:0] rem_reg, rem_next;
    logic [NUM_BITS-1:0] qt_reg, qt_next;
    logic [DEN_BITS:0]   trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        qt_next   = qt_reg;
        trial     = {rem_reg, qt_reg[NUM_BITS-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(NUM_BITS - 1);
            rem_next  = '0;
            qt_next   = num;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den}) begin
                rem_next = DEN_BITS'(trial - {1'b0, den});
                qt_next  = {qt_reg[NUM_BITS-2:0], 1'b1};
            end else begin
                rem_next = trial[DEN_BITS-1:0];
                qt_next  = {qt_reg[NUM_BITS-2:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        qt_reg  <= qt_next;
    end

    assign done = done_reg;
    assign quot = qt_reg;
endmodule
`default_nettype wire

// ===== src/p2_streaming_quantile.sv =====
// p-square streaming quantile estimator, top level
//
//  channel   dir  handshake                 content
//  s_        in   s_tvalid / s_tready       sample in tdata, last_sample on tlast
//  m_        out  m_tvalid / m_tready       estimate in tdata, estimate_valid on tuser
//  apb       in   psel, penable, pready     quantile_level at byte address 0
//
//  the first four samples of a set go from S_IDLE straight to S_FIN; the fifth first takes
//  16 bubble-sort steps; a later sample is checked in S_CHK for each inner marker, and one
//  that moves takes the parabolic step (three divisions) and, if that is rejected or not
//  allowed, the linear step (one division); each division runs on the serial divider psq_div
//  s_tready is high only while the sequencer is idle; a result waits in the output register
//  and the next item is accepted meanwhile; a last item stalls only if that register is full
//  aresetn is synchronous, active low, and restores all marker state and the level register
`default_nettype none
module p2_streaming_quantile #(
    parameter int SAMPLE_BITS = psq_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = psq_pkg::COUNT_BITS_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    // sample [SAMPLE_BITS-1:0], zero padded to bytes
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    input  wire logic s_tvalid,
    input  wire logic s_tlast,
    output logic      s_tready,
    // estimate [31:0]
    output logic [31:0] m_tdata,
    // estimate_valid [0]
    output logic [0:0]  m_tuser,
    output logic        m_tvalid,
    input  wire logic   m_tready,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import psq_pkg::*;

    localparam int CB = COUNT_BITS;
    localparam int DB = COUNT_BITS + FRAC_BITS;
    localparam int NW = COUNT_BITS + 33;
    localparam int HB = HEIGHT_BITS;
    localparam logic [DB-1:0] ONE_D = DB'(1) << FRAC_BITS;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SORT = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_MUL1 = 4'd3;
    localparam logic [3:0] S_D1W  = 4'd4;
    localparam logic [3:0] S_MUL2 = 4'd5;
    localparam logic [3:0] S_D2W  = 4'd6;
    localparam logic [3:0] S_D3W  = 4'd7;
    localparam logic [3:0] S_PCHK = 4'd8;
    localparam logic [3:0] S_LIN  = 4'd9;
    localparam logic [3:0] S_LW   = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;

    // marker state
    logic signed [HB-1:0] height_reg [MARKERS];
    logic signed [HB-1:0] height_next [MARKERS];
    logic [CB-1:0] pos_reg [MARKERS];
    logic [CB-1:0] pos_next [MARKERS];
    logic [DB-1:0] des_reg [MARKERS];
    logic [DB-1:0] des_next [MARKERS];
    logic [CB-1:0] seen_reg, seen_next;
    logic [LEVEL_BITS-1:0] qlevel_reg;

    // sequencer
    logic [3:0] state_reg, state_next;
    logic [2:0] idx_reg, idx_next;
    logic [3:0] sort_cnt_reg, sort_cnt_next;
    logic       last_reg, last_next;
    logic       dir_reg, dir_next;
    logic       neg_reg, neg_next;
    logic [CB-1:0] a_reg, a_next, b_reg, b_next;
    logic [31:0]   gu_reg, gu_next, gd_reg, gd_next;
    logic [NW-1:0] t1_reg, t1_next, t_reg, t_next;

    // divider interface
    logic          div_start_reg, div_start_next;
    logic [NW-1:0] div_num_reg, div_num_next;
    logic [CB-1:0] div_den_reg, div_den_next;
    logic          div_done;
    logic [NW-1:0] div_quot;

    // output register
    logic          out_valid_reg, out_valid_next;
    logic [HB-1:0] est_reg, est_next;
    logic          estv_reg, estv_next;

    psq_div #(.NUM_BITS(NW), .DEN_BITS(CB)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .num     (div_num_reg),
        .den     (div_den_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    // config port
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_QLEVEL);
    assign prdata = (paddr[2] == REG_QLEVEL) ? {16'b0, qlevel_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qlevel_reg <= LEVEL_RESET;
        end else if (cfg_wr) begin
            qlevel_reg <= pwdata[LEVEL_BITS-1:0];
        end
    end

    // sample scaled to q24.8 with saturation
    logic signed [40:0] h_wide;
    logic signed [HB-1:0] h_sat;
    always_comb begin
        h_wide = 41'(signed'(s_tdata[SAMPLE_BITS-1:0])) <<< 8;
        if (h_wide > 41'sd2147483647) begin
            h_sat = 32'sh7fffffff;
        end else if (h_wide < -41'sd2147483648) begin
            h_sat = 32'sh80000000;
        end else begin
            h_sat = h_wide[HB-1:0];
        end
    end

    // neighbors of the marker under adjustment
    logic signed [HB-1:0] q, lo, hi;
    logic [CB-1:0] pq, plo, phi, above, below;
    logic [DB-1:0] drift;
    logic up_ok, dn_ok, par_ok;
    logic signed [HB:0] gu_w, gd_w;
    always_comb begin
        q     = height_reg[idx_reg];
        lo    = height_reg[idx_reg - 3'd1];
        hi    = height_reg[idx_reg + 3'd1];
        pq    = pos_reg[idx_reg];
        plo   = pos_reg[idx_reg - 3'd1];
        phi   = pos_reg[idx_reg + 3'd1];
        above = phi - pq;
        below = pq - plo;
        drift = des_reg[idx_reg] - {pq, {FRAC_BITS{1'b0}}};
        up_ok = ($signed(drift) >= $signed(ONE_D)) && ($signed(above) > $signed(CB'(1)));
        dn_ok = ($signed(drift) <= -$signed(ONE_D)) && ($signed(below) > $signed(CB'(1)));
        par_ok = ($signed(below) >= $signed(CB'(1))) && ($signed(above) >= $signed(CB'(1)))
                 && (hi >= q) && (q >= lo);
        gu_w = {hi[HB-1], hi} - {q[HB-1], q};
        gd_w = {q[HB-1], q} - {lo[HB-1], lo};
    end

    // parabolic and linear helpers
    logic [CB-1:0]   a_eff, b_eff;
    logic [CB+31:0]  prod;
    logic signed [NW+1:0] qw, low_w, hiw_w, tw, qp;
    logic signed [HB:0] ldiff, lmag, lstep, lnew;
    always_comb begin
        a_eff = dir_reg ? a_reg + 1'b1 : a_reg - 1'b1;
        b_eff = dir_reg ? b_reg - 1'b1 : b_reg + 1'b1;
        prod  = (state_reg == S_MUL1) ? a_eff * gu_reg : b_eff * gd_reg;
        qw    = (NW+2)'(q);
        low_w = (NW+2)'(lo);
        hiw_w = (NW+2)'(hi);
        tw    = {2'b00, t_reg};
        qp    = dir_reg ? qw + tw : qw - tw;
        ldiff = dir_reg ? ({hi[HB-1], hi} - {q[HB-1], q}) : ({lo[HB-1], lo} - {q[HB-1], q});
        lmag  = ldiff[HB] ? -ldiff : ldiff;
        lstep = neg_reg ? -{1'b0, div_quot[HB-1:0]} : {1'b0, div_quot[HB-1:0]};
        lnew  = {q[HB-1], q} + lstep;
    end

    logic [1:0] cell_sel;
    logic       below_all, above_all;
    logic [2:0] sj;

    always_comb begin
        for (int k = 0; k < MARKERS; k++) begin
            height_next[k] = height_reg[k];
            pos_next[k]    = pos_reg[k];
            des_next[k]    = des_reg[k];
        end
        seen_next      = seen_reg;
        state_next     = state_reg;
        idx_next       = idx_reg;
        sort_cnt_next  = sort_cnt_reg;
        last_next      = last_reg;
        dir_next       = dir_reg;
        neg_next       = neg_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        gu_next        = gu_reg;
        gd_next        = gd_reg;
        t1_next        = t1_reg;
        t_next         = t_reg;
        div_start_next = 1'b0;
        div_num_next   = div_num_reg;
        div_den_next   = div_den_reg;
        out_valid_next = out_valid_reg && !m_tready;
        est_next       = est_reg;
        estv_next      = estv_reg;
        below_all      = h_sat < height_reg[0];
        above_all      = h_sat > height_reg[4];
        cell_sel       = 2'd0;
        sj             = {1'b0, sort_cnt_reg[1:0]};

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    last_next = s_tlast;
                    if (seen_reg < CB'(MARKERS)) begin
                        height_next[seen_reg[2:0]] = h_sat;
                        seen_next = seen_reg + 1'b1;
                        if (seen_reg == CB'(MARKERS - 1)) begin
                            sort_cnt_next = '0;
                            state_next    = S_SORT;
                        end else begin
                            state_next = S_FIN;
                        end
                    end else begin
                        if (below_all) begin
                            height_next[0] = h_sat;
                            cell_sel = 2'd0;
                        end else if (above_all) begin
                            height_next[4] = h_sat;
                            cell_sel = 2'd3;
                        end else begin
                            cell_sel = 2'((height_reg[1] < h_sat) ? 1 : 0)
                                     + 2'((height_reg[2] < h_sat) ? 1 : 0)
                                     + 2'((height_reg[3] < h_sat) ? 1 : 0);
                        end
                        for (int k = 1; k < MARKERS; k++) begin
                            if (k > int'(cell_sel)) begin
                                pos_next[k] = pos_reg[k] + 1'b1;
                            end
                        end
                        des_next[1] = des_reg[1] + DB'(qlevel_reg >> 1);
                        des_next[2] = des_reg[2] + DB'(qlevel_reg);
                        des_next[3] = des_reg[3]
                                    + DB'(({1'b0, qlevel_reg} + 17'h10000) >> 1);
                        des_next[4] = des_reg[4] + ONE_D;
                        if (seen_reg != {CB{1'b1}}) begin
                            seen_next = seen_reg + 1'b1;
                        end
                        idx_next   = 3'd1;
                        state_next = S_CHK;
                    end
                end
            end
            S_SORT: begin
                // bubble passes over adjacent pairs
                if (height_reg[sj] > height_reg[sj + 3'd1]) begin
                    height_next[sj]        = height_reg[sj + 3'd1];
                    height_next[sj + 3'd1] = height_reg[sj];
                end
                sort_cnt_next = sort_cnt_reg + 1'b1;
                if (sort_cnt_reg == 4'd15) begin
                    des_next[0] = '0;
                    des_next[1] = DB'({qlevel_reg, 1'b0});
                    des_next[2] = DB'({qlevel_reg, 2'b0});
                    des_next[3] = DB'({qlevel_reg, 1'b0}) + (ONE_D << 1);
                    des_next[4] = ONE_D << 2;
                    state_next  = S_FIN;
                end
            end
            S_CHK: begin
                a_next  = below;
                b_next  = above;
                gu_next = gu_w[31:0];
                gd_next = gd_w[31:0];
                if (up_ok || dn_ok) begin
                    dir_next   = up_ok;
                    state_next = par_ok ? S_MUL1 : S_LIN;
                end else if (idx_reg == 3'd3) begin
                    state_next = S_FIN;
                end else begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            S_MUL1: begin
                div_num_next   = NW'(prod);
                div_den_next   = b_reg;
                div_start_next = 1'b1;
                state_next     = S_D1W;
            end
            S_D1W: begin
                if (div_done) begin
                    t1_next    = div_quot;
                    state_next = S_MUL2;
                end
            end
            S_MUL2: begin
                div_num_next   = NW'(prod);
                div_den_next   = a_reg;
                div_start_next = 1'b1;
                state_next     = S_D2W;
            end
            S_D2W: begin
                if (div_done) begin
                    div_num_next   = t1_reg + div_quot;
                    div_den_next   = a_reg + b_reg;
                    div_start_next = 1'b1;
                    state_next     = S_D3W;
                end
            end
            S_D3W: begin
                if (div_done) begin
                    t_next     = div_quot;
                    state_next = S_PCHK;
                end
            end
            S_PCHK: begin
                if ((qp > low_w) && (qp < hiw_w)) begin
                    height_next[idx_reg] = qp[HB-1:0];
                    pos_next[idx_reg] = dir_reg ? pq + 1'b1 : pq - 1'b1;
                    if (idx_reg == 3'd3) begin
                        state_next = S_FIN;
                    end else begin
                        idx_next   = idx_reg + 3'd1;
                        state_next = S_CHK;
                    end
                end else begin
                    state_next = S_LIN;
                end
            end
            S_LIN: begin
                // move toward the neighbor by its gap over the position distance, truncated toward zero
                neg_next       = ldiff[HB];
                div_num_next   = NW'(lmag[HB-1:0]);
                div_den_next   = dir_reg ? above : below;
                div_start_next = 1'b1;
                state_next     = S_LW;
            end
            S_LW: begin
                if (div_done) begin
                    height_next[idx_reg] = lnew[HB-1:0];
                    pos_next[idx_reg] = dir_reg ? pq + 1'b1 : pq - 1'b1;
                    if (idx_reg == 3'd3) begin
                        state_next = S_FIN;
                    end else begin
                        idx_next   = idx_reg + 3'd1;
                        state_next = S_CHK;
                    end
                end
            end
            S_FIN: begin
                if (!last_reg) begin
                    state_next = S_IDLE;
                end else if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    estv_next      = seen_reg >= CB'(MARKERS);
                    est_next       = (seen_reg >= CB'(MARKERS)) ? height_reg[2] : '0;
                    for (int k = 0; k < MARKERS; k++) begin
                        height_next[k] = '0;
                        pos_next[k]    = CB'(k);
                        des_next[k]    = '0;
                    end
                    seen_next  = '0;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MARKERS; k++) begin
                height_reg[k] <= '0;
                pos_reg[k]    <= CB'(k);
                des_reg[k]    <= '0;
            end
            seen_reg      <= '0;
            state_reg     <= S_IDLE;
            idx_reg       <= 3'd1;
            sort_cnt_reg  <= '0;
            last_reg      <= 1'b0;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            for (int k = 0; k < MARKERS; k++) begin
                height_reg[k] <= height_next[k];
                pos_reg[k]    <= pos_next[k];
                des_reg[k]    <= des_next[k];
            end
            seen_reg      <= seen_next;
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            sort_cnt_reg  <= sort_cnt_next;
            last_reg      <= last_next;
            div_start_reg <= div_start_next;
            out_valid_reg <= out_valid_next;
        end
        dir_reg     <= dir_next;
        neg_reg     <= neg_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        gu_reg      <= gu_next;
        gd_reg      <= gd_next;
        t1_reg      <= t1_next;
        t_reg       <= t_next;
        div_num_reg <= div_num_next;
        div_den_reg <= div_den_next;
        est_reg     <= est_next;
        estv_reg    <= estv_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = est_reg;
    assign m_tuser  = estv_reg;
endmodule
`default_nettype wire
